// File: design/lz77_ring_decompressor_defines.svh
// ---------------------------------------------------------------------------
// lz77 ring decompressor assertion macros
// shared property wrappers for the block's checks
// ---------------------------------------------------------------------------
`ifndef LZ77_RING_DECOMPRESSOR_DEFINES_SVH
`define LZ77_RING_DECOMPRESSOR_DEFINES_SVH

// same-cycle implication
`define LZR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LZR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/lzr_pkg.sv
// ---------------------------------------------------------------------------
// lzr_pkg
// shared constants and types of the lz77 ring decompressor
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lzr_pkg;

  localparam int HIST_DEPTH = 4096;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int MIN_MATCH  = 3;
  localparam int MAX_RUN    = 18;
  localparam int LEN_W      = 5;
  localparam int DIST_W     = 12;
  localparam int CNT_W      = 32;
  localparam int BYTE_W     = 8;

  typedef struct packed {
    logic              last;
    logic [BYTE_W-1:0] data;
  } lzr_beat_t;

endpackage

`default_nettype wire

// File: design/lzr_ram.sv
// ---------------------------------------------------------------------------
// lzr_ram
// single-port-write, single-port-read memory with registered read data
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lzr_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: design/lzr_out_reg.sv
// ---------------------------------------------------------------------------
// lzr_out_reg
// output register stage for decompressed bytes
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lzr_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              beat_valid,
  input  wire lzr_pkg::lzr_beat_t beat,
  output logic                   beat_ready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [7:0]             out_tdata,  // [7:0] out_byte
  output logic                   out_tlast   // run_last
);
  import lzr_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  lzr_beat_t beat_r;

  assign beat_ready = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (beat_ready) begin
      valid_nxt = beat_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (beat_ready && beat_valid) begin
      beat_r <= beat;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = beat_r.data;
  assign out_tlast  = beat_r.last;

endmodule

`default_nettype wire

// File: design/lz77_ring_decompressor.sv
// ---------------------------------------------------------------------------
// lz77_ring_decompressor
// lz77 decoder with a 4096-byte history ring held in a synchronous memory
// ---------------------------------------------------------------------------
// control and match low bytes: accepted in S_IDLE, no output
// literal: S_LIT hands the byte to the output register, which drives out_tvalid; no new input is taken until then
// match: the high byte starts a history read, then S_MATCH passes one byte per cycle
//   out of the history memory's read port while the output register is not stalled, no input meanwhile
// reset: synchronous; history reads as zero through a fill pointer, no
//   clearing pass, so the block takes input right after reset and block end
`timescale 1ns / 1ps
`default_nettype none
`include "lz77_ring_decompressor_defines.svh"

module lz77_ring_decompressor (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  input  wire logic        in_tlast,   // block_last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] out_byte
  output logic             out_tlast,  // run_last
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data    // [31:0] output_limit
);
  import lzr_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LIT   = 2'd1;
  localparam logic [1:0] S_MATCH = 2'd2;

  localparam logic [1:0] PH_CTRL = 2'd0;
  localparam logic [1:0] PH_ITEM = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;

  logic [1:0]         state_r,   state_nxt;
  logic [1:0]         phase_r,   phase_nxt;
  logic [7:0]         flags_r,   flags_nxt;
  logic [2:0]         fidx_r,    fidx_nxt;
  logic [7:0]         low_r,     low_nxt;
  logic [HIST_AW-1:0] wp_r,      wp_nxt;
  logic               wrapped_r, wrapped_nxt;
  logic [CNT_W-1:0]   count_r,   count_nxt;
  logic [CNT_W-1:0]   limit_r,   limit_nxt;
  logic [LEN_W-1:0]   rem_r,     rem_nxt;
  logic               blast_r,   blast_nxt;
  logic               rdok_r,    rdok_nxt;
  logic               fwd_hit_r, fwd_hit_nxt;
  logic [7:0]         byte_r,    byte_nxt;
  logic [HIST_AW-1:0] src_r,     src_nxt;
  logic [7:0]         fwd_data_r;

  logic               in_xfer;
  logic               live;
  logic               do_clear;
  logic               run_end;
  logic [15:0]        word;
  logic [DIST_W-1:0]  back_dist;
  logic [LEN_W-1:0]   len_raw;
  logic [LEN_W-1:0]   len;
  logic [HIST_AW-1:0] src_first;

  logic               ram_we;
  logic               ram_re;
  logic [HIST_AW-1:0] ram_raddr;
  logic [7:0]         ram_wdata;
  logic [7:0]         ram_rdata;
  logic [7:0]         hist_byte;

  logic               beat_valid;
  logic               beat_ready;
  lzr_beat_t          beat;

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_tvalid && in_tready;
  assign live      = (count_r < limit_r);
  assign run_end   = (rem_r == LEN_W'(1)) ||
                     (({1'b0, count_r} + (CNT_W+1)'(1)) == {1'b0, limit_r});

  assign word      = {in_tdata, low_r};
  assign back_dist = word[15:4];
  assign len_raw   = LEN_W'(word[3:0]) + LEN_W'(MIN_MATCH);
  assign len       = (len_raw > LEN_W'(MAX_RUN)) ? LEN_W'(MAX_RUN) : len_raw;
  assign src_first = wp_r - HIST_AW'(back_dist) - HIST_AW'(1);

  assign hist_byte = !rdok_r ? 8'h00 : (fwd_hit_r ? fwd_data_r : ram_rdata);

  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    flags_nxt   = flags_r;
    fidx_nxt    = fidx_r;
    low_nxt     = low_r;
    wp_nxt      = wp_r;
    wrapped_nxt = wrapped_r;
    count_nxt   = count_r;
    limit_nxt   = limit_r;
    rem_nxt     = rem_r;
    blast_nxt   = blast_r;
    byte_nxt    = byte_r;
    src_nxt     = src_r;
    rdok_nxt    = rdok_r;
    fwd_hit_nxt = fwd_hit_r;
    do_clear    = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = src_r;
    ram_wdata   = byte_r;
    beat_valid  = 1'b0;
    beat.last   = 1'b1;
    beat.data   = byte_r;

    if (cfg_valid && cfg_ready) begin
      limit_nxt = cfg_data;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          blast_nxt = in_tlast;
          byte_nxt  = in_tdata;
          if (live) begin
            case (phase_r)
              PH_CTRL: begin
                flags_nxt = in_tdata;
                fidx_nxt  = 3'd0;
                phase_nxt = PH_ITEM;
              end
              PH_ITEM: begin
                if (flags_r[fidx_r]) begin
                  low_nxt   = in_tdata;
                  phase_nxt = PH_HIGH;
                end else begin
                  state_nxt = S_LIT;
                end
              end
              PH_HIGH: begin
                rem_nxt   = len;
                ram_re    = 1'b1;
                ram_raddr = src_first;
                src_nxt   = src_first + HIST_AW'(1);
                state_nxt = S_MATCH;
              end
              default: begin
                phase_nxt = PH_CTRL;
              end
            endcase
          end
          if (in_tlast && (state_nxt == S_IDLE)) begin
            do_clear = 1'b1;
          end
        end
      end
      S_LIT: begin
        beat_valid = 1'b1;
        if (beat_ready) begin
          ram_we    = 1'b1;
          wp_nxt    = wp_r + HIST_AW'(1);
          count_nxt = count_r + CNT_W'(1);
          if (wp_r == {HIST_AW{1'b1}}) begin
            wrapped_nxt = 1'b1;
          end
          fidx_nxt  = fidx_r + 3'd1;
          phase_nxt = (fidx_r == 3'd7) ? PH_CTRL : PH_ITEM;
          state_nxt = S_IDLE;
          do_clear  = blast_r;
        end
      end
      S_MATCH: begin
        beat_valid = 1'b1;
        beat.data  = hist_byte;
        beat.last  = run_end;
        ram_wdata  = hist_byte;
        if (beat_ready) begin
          ram_we    = 1'b1;
          wp_nxt    = wp_r + HIST_AW'(1);
          count_nxt = count_r + CNT_W'(1);
          if (wp_r == {HIST_AW{1'b1}}) begin
            wrapped_nxt = 1'b1;
          end
          if (run_end) begin
            fidx_nxt  = fidx_r + 3'd1;
            phase_nxt = (fidx_r == 3'd7) ? PH_CTRL : PH_ITEM;
            state_nxt = S_IDLE;
            do_clear  = blast_r;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = src_r;
            src_nxt   = src_r + HIST_AW'(1);
            rem_nxt   = rem_r - LEN_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // entry valid if written this block; same-cycle write is forwarded
    if (ram_re) begin
      fwd_hit_nxt = ram_we && (wp_r == ram_raddr);
      rdok_nxt    = wrapped_r || (ram_raddr < wp_r) || fwd_hit_nxt;
    end

    if (do_clear) begin
      wp_nxt      = '0;
      wrapped_nxt = 1'b0;
      phase_nxt   = PH_CTRL;
      flags_nxt   = 8'h00;
      fidx_nxt    = 3'd0;
      low_nxt     = 8'h00;
      count_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      phase_r   <= PH_CTRL;
      flags_r   <= 8'h00;
      fidx_r    <= 3'd0;
      low_r     <= 8'h00;
      wp_r      <= '0;
      wrapped_r <= 1'b0;
      count_r   <= '0;
      limit_r   <= {CNT_W{1'b1}};
      rem_r     <= '0;
      blast_r   <= 1'b0;
      rdok_r    <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      phase_r   <= phase_nxt;
      flags_r   <= flags_nxt;
      fidx_r    <= fidx_nxt;
      low_r     <= low_nxt;
      wp_r      <= wp_nxt;
      wrapped_r <= wrapped_nxt;
      count_r   <= count_nxt;
      limit_r   <= limit_nxt;
      rem_r     <= rem_nxt;
      blast_r   <= blast_nxt;
      rdok_r    <= rdok_nxt;
      fwd_hit_r <= fwd_hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    src_r  <= src_nxt;
    if (ram_re) begin
      fwd_data_r <= ram_wdata;
    end
  end

  lzr_ram #(
    .DEPTH (HIST_DEPTH),
    .AW    (HIST_AW),
    .DW    (8)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lzr_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_valid (beat_valid),
    .beat       (beat),
    .beat_ready (beat_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  `LZR_ASSERT_NOW(a_limit_kept, beat_valid && beat_ready, count_r < limit_r, "byte past limit")
  `LZR_ASSERT_NOW(a_match_rem, state_r == S_MATCH, rem_r != '0, "match with no bytes left")
  `LZR_ASSERT_NEXT(a_block_end, beat_valid && beat_ready && beat.last && blast_r,
    (wp_r == '0) && (count_r == '0) && (phase_r == PH_CTRL), "block state not cleared")
  `LZR_ASSERT_NEXT(a_match_start, in_xfer && live && (phase_r == PH_HIGH),
    state_r == S_MATCH, "high byte did not start a match")

endmodule

`default_nettype wire

// File: tb/lz77_ring_decompressor_tb.sv
// ---------------------------------------------------------------------------
// lz77_ring_decompressor_tb
// Drives compressed byte streams into the lz77 ring decompressor and checks
// every output byte and its end-of-run flag against a predictor. The
// predictor decodes each accepted input byte with its own history ring.
// Covered: literals, short and long matches, overlapping copies, far
// distances, truncated matches, bare control bytes, several output limits,
// random back-pressure and a long output stall.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lz77_ring_decompressor_tb;
  import lzr_pkg::*;

  localparam int          DRAIN_CYCLES   = 40;
  localparam int          RX_HOLD_CYCLES = 500;
  localparam int          LIMIT_CYCLES   = 300000;
  localparam logic [31:0] LIMIT_NONE     = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {WAIT_CTRL, WAIT_ITEM, WAIT_HIGH} dec_phase_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] in_byte
  logic        in_tlast = 1'b0; // block_last
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // [7:0] out_byte
  logic        out_tlast;       // run_last
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;   // [31:0] output_limit

  // predictor state
  logic [7:0]         hist [HIST_DEPTH];
  logic [HIST_AW-1:0] wr_pos;
  dec_phase_t         dphase;
  logic [7:0]         flags;
  logic [2:0]         flag_idx;
  logic [7:0]         low_byte;
  logic [31:0]        n_out;
  logic [31:0]        out_limit;

  lzr_beat_t in_items[$];
  lzr_beat_t exp_out[$];

  int  n_queued = 0;
  int  n_accepted = 0;
  int  n_checked = 0;
  int  n_blocks = 0;
  int  err_cnt = 0;
  int  cycles = 0;
  int  tx_gap = 0;
  int  rx_wait = 0;
  bit  tx_no_idle = 1'b0;
  bit  rx_no_idle = 1'b0;
  logic rx_hold = 1'b0;

  lz77_ring_decompressor i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void clear_block();
    foreach (hist[i]) hist[i] = 8'h00;
    wr_pos   = '0;
    dphase   = WAIT_CTRL;
    flags    = 8'h00;
    flag_idx = 3'd0;
    low_byte = 8'h00;
    n_out    = '0;
  endfunction

  function automatic void emit_byte(input logic [7:0] b);
    exp_out.push_back('{last: 1'b0, data: b});
    hist[wr_pos] = b;
    wr_pos = wr_pos + 1'b1;
    n_out = n_out + 1;
  endfunction

  function automatic void advance_flag();
    flag_idx = flag_idx + 1'b1;
    dphase = (flag_idx == 3'd0) ? WAIT_CTRL : WAIT_ITEM;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic blk_end);
    int                 n0;
    int                 run_len;
    logic [15:0]        word;
    logic [HIST_AW-1:0] src;
    lzr_beat_t          tail;
    n0 = exp_out.size();
    if (n_out < out_limit) begin
      case (dphase)
        WAIT_CTRL: begin
          flags = b;
          flag_idx = 3'd0;
          dphase = WAIT_ITEM;
        end
        WAIT_ITEM: begin
          if (flags[flag_idx]) begin
            low_byte = b;
            dphase = WAIT_HIGH;
          end else begin
            emit_byte(b);
            advance_flag();
          end
        end
        default: begin
          word = {b, low_byte};
          run_len = int'(word[3:0]) + MIN_MATCH;
          if (run_len > MAX_RUN) run_len = MAX_RUN;
          for (int j = 0; j < run_len && n_out < out_limit; j++) begin
            src = wr_pos - HIST_AW'(word[15:4]) - HIST_AW'(1);
            emit_byte(hist[src]);
          end
          advance_flag();
        end
      endcase
    end
    if (exp_out.size() > n0) begin
      tail = exp_out.pop_back();
      tail.last = 1'b1;
      exp_out.push_back(tail);
    end
    if (blk_end) clear_block();
  endfunction

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= 20) $display("mismatch at cycle %0d: %s", cycles, msg);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic blk_end);
    in_items.push_back('{last: blk_end, data: b});
    n_queued++;
    if (blk_end) n_blocks++;
  endtask

  // well-formed block: control bytes with random flags, literals and matches
  task automatic gen_block(input int n_bytes, input int match_pct);
    lzr_beat_t  blk[$];
    logic [7:0] ctrl;
    int         span;
    int         back_dist;
    int         len_code;
    span = 0;
    while (blk.size() < n_bytes) begin
      for (int f = 0; f < 8; f++) ctrl[f] = ($urandom_range(0, 99) < match_pct);
      blk.push_back('{last: 1'b0, data: ctrl});
      for (int f = 0; f < 8 && blk.size() < n_bytes; f++) begin
        if (ctrl[f]) begin
          if (span > 0 && $urandom_range(0, 3) != 0)
            back_dist = $urandom_range(0, (span > 64) ? 63 : span - 1);
          else
            back_dist = $urandom_range(0, 4095);
          len_code = $urandom_range(0, 15);
          blk.push_back('{last: 1'b0, data: {back_dist[3:0], len_code[3:0]}});
          blk.push_back('{last: 1'b0, data: back_dist[11:4]});
          span += len_code + MIN_MATCH;
        end else begin
          blk.push_back('{last: 1'b0, data: 8'($urandom)});
          span++;
        end
      end
    end
    foreach (blk[i]) push_byte(blk[i].data, i == blk.size() - 1);
  endtask

  task automatic drain();
    do @(posedge clk); while (n_accepted != n_queued || exp_out.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [31:0] v);
    @(posedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    out_limit = v;
  endtask

  // input side: one transfer per item, random gap after each item
  always @(posedge clk) begin : drv
    logic      busy;
    lzr_beat_t nxt;
    if (rst_n) begin
      busy = in_tvalid;
      if (in_tvalid && in_tready) begin
        decode_byte(in_tdata, in_tlast);
        n_accepted++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (in_items.size() != 0) begin
          nxt = in_items.pop_front();
          in_tdata <= nxt.data;
          in_tlast <= nxt.last;
          busy = 1'b1;
          tx_gap = tx_no_idle ? 0 : $urandom_range(0, 4);
        end
      end
      in_tvalid <= busy;
    end
  end

  // output side: check each transfer, random stall after each one
  always @(posedge clk) begin : mon
    lzr_beat_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        n_checked++;
        if (exp_out.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h", out_tdata));
        end else begin
          want = exp_out.pop_front();
          if (out_tdata !== want.data)
            report_mismatch($sformatf("out_byte %02h, expected %02h", out_tdata, want.data));
          if (out_tlast !== want.last)
            report_mismatch($sformatf("run_last %b, expected %b", out_tlast, want.last));
        end
        rx_wait = rx_no_idle ? 0 : $urandom_range(0, 4);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !rx_hold;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    clear_block();
    out_limit = LIMIT_NONE;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // literals at both extremes, longest match at distance zero, farthest
    // distance, short overlapping match ending the block
    push_byte(8'h54, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h0F, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hA5, 1'b0);
    push_byte(8'hF0, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h5A, 1'b0);
    push_byte(8'h24, 1'b0);
    push_byte(8'h00, 1'b1);
    // match cut off after its low byte
    push_byte(8'hFF, 1'b0);
    push_byte(8'h3C, 1'b1);
    // control byte alone in its block
    push_byte(8'hC3, 1'b1);
    drain();

    // nothing comes out with a zero limit
    write_limit(32'd0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h77, 1'b1);
    drain();

    // match cut at the limit, later bytes ignored
    write_limit(32'd5);
    push_byte(8'h02, 1'b0);
    push_byte(8'h11, 1'b0);
    push_byte(8'h0F, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h22, 1'b1);
    drain();

    write_limit(LIMIT_NONE);
    repeat (3) gen_block($urandom_range(10, 30), 40);
    drain();

    // long output stall while the sender keeps offering
    fork
      begin
        rx_hold <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    tx_no_idle = 1'b1;
    repeat (3) gen_block(20, 70);
    drain();
    tx_no_idle = 1'b0;

    repeat (3) begin
      write_limit($urandom_range(1, 40));
      repeat (2) gen_block($urandom_range(6, 16), 50);
      drain();
    end

    write_limit(LIMIT_NONE);
    tx_no_idle = 1'b1;
    rx_no_idle = 1'b1;
    gen_block(20, 50);
    drain();
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;

    // unstructured bytes with random block ends
    for (int i = 0; i < 30; i++)
      push_byte(8'($urandom), (i == 29) || ($urandom_range(0, 9) == 0));
    drain();

    if (exp_out.size() != 0)
      report_mismatch($sformatf("%0d expected bytes never came out", exp_out.size()));
    $display("%0d compressed bytes in %0d blocks, %0d decompressed bytes checked",
             n_accepted, n_blocks, n_checked);
    $display("limits zero, five, random small and none; random stalls and a long output hold");
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
